@@ hw/rtl/image_block_pooling_macros.svh @@
// ----------------------------------------------------------------------------
// image_block_pooling assertion macros
// Shared concurrent assertion forms for the block pooling RTL.
// ----------------------------------------------------------------------------
`ifndef IMAGE_BLOCK_POOLING_MACROS_SVH
`define IMAGE_BLOCK_POOLING_MACROS_SVH

// same-cycle implication
`define IBP_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ibp assertion failed");

// next-cycle implication
`define IBP_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ibp assertion failed");

`endif

@@ hw/rtl/ibp_pkg.sv @@
// ----------------------------------------------------------------------------
// ibp_pkg
// Types and constants of the image block pooling block.
// ----------------------------------------------------------------------------
package ibp_pkg;

	localparam int ACC_W      = 44;
	localparam int COL_W      = 12;
	localparam int ROW_W      = 10;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int COL_LIMIT  = 4096;

	localparam int MAX_OUT_ROWS_DEF = 1024;
	localparam int MAX_FACTOR_DEF   = 64;
	localparam int PIXEL_BITS_DEF   = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 3'd0,
		REG_COL_FACTOR = 3'd1,
		REG_ROW_FACTOR = 3'd2,
		REG_OUT_ROWS   = 3'd3,
		REG_OUT_COLS   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SUM = 2'd0,
		MODE_AVG = 2'd1,
		MODE_MAX = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_PUSH
	} state_t;

endpackage

@@ hw/rtl/ibp_div.sv @@
// ----------------------------------------------------------------------------
// ibp_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module ibp_div import ibp_pkg::*; #(
	parameter int DW = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] num,
	input  logic [DW-1:0]           den,
	output logic                    done,
	output logic signed [ACC_W-1:0] quo
);

	localparam int CW = $clog2(ACC_W);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic [ACC_W-1:0] quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [DW:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[ACC_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[ACC_W-1];
			quo_q <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
			rem_q <= '0;
			den_q <= den;
			cnt_q <= CW'(ACC_W - 1);
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
			quo_q <= {quo_q[ACC_W-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

@@ hw/rtl/image_block_pooling.sv @@
// ----------------------------------------------------------------------------
// image_block_pooling
// Sum, average or max pooling of a column-major pixel stream over tiles.
// ----------------------------------------------------------------------------
// Usage: pixels enter on in_valid/in_ready, column by column and down each
// column; one transaction per pixel. A tile result leaves on
// out_valid/out_ready with value, out_col, out_row and last_of_image.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle; the block does not enforce it. For each pixel
// the row accumulator is read from the single-port accumulator memory on
// accept, then updated and written back in the update state. A tile result
// in sum or max mode passes through the push state into the output register;
// in average mode the serial divider runs first. The output register holds a
// result while the receiver stalls; the next pixel is still taken, and the
// block waits only when a second result meets a full output register.
// Reset clears counters, registers (mode sum, all counts 1) and the output
// valid; the accumulator memory is not cleared, the first pixel of each
// tile starts its accumulator fresh.
// ----------------------------------------------------------------------------
module image_block_pooling import ibp_pkg::*; #(
	parameter int MAX_OUT_ROWS = MAX_OUT_ROWS_DEF,
	parameter int MAX_FACTOR   = MAX_FACTOR_DEF,
	parameter int PIXEL_BITS   = PIXEL_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [PIXEL_BITS-1:0] pixel,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [ACC_W-1:0]      value,
	output logic [COL_W-1:0]             out_col,
	output logic [ROW_W-1:0]             out_row,
	output logic                         last_of_image
);

	`include "image_block_pooling_macros.svh"

	localparam int FW  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int FCW = $clog2(MAX_FACTOR + 1);
	localparam int DW  = 2 * FCW;
	localparam int RW  = (MAX_OUT_ROWS > 1) ? $clog2(MAX_OUT_ROWS) : 1;
	localparam int NRW = $clog2(MAX_OUT_ROWS + 1);
	localparam int NCW = $clog2(COL_LIMIT + 1);
	localparam int XW  = ((PIXEL_BITS > ACC_W) ? PIXEL_BITS : ACC_W) + 1;

	logic [1:0]  mode_q;
	logic [6:0]  col_factor_q;
	logic [6:0]  row_factor_q;
	logic [10:0] out_rows_q;
	logic [12:0] out_cols_q;

	state_t state_q, state_d;

	logic [FW-1:0]    row_in_tile_q;
	logic [FW-1:0]    col_in_tile_q;
	logic [RW-1:0]    row_index_out_q;
	logic [COL_W-1:0] col_index_out_q;

	logic signed [ACC_W-1:0] mem [MAX_OUT_ROWS];
	logic signed [ACC_W-1:0] rd_data_s1;
	logic signed [XW-1:0]    px_s1;

	logic signed [ACC_W-1:0] res_value_q;
	logic [COL_W-1:0]        res_col_q;
	logic [ROW_W-1:0]        res_row_q;
	logic                    res_last_q;

	logic                    out_valid_q;
	logic signed [ACC_W-1:0] value_q;
	logic [COL_W-1:0]        out_col_q;
	logic [ROW_W-1:0]        out_row_q;
	logic                    out_last_q;

	logic [FCW-1:0] cf, rf;
	logic [NRW-1:0] nr;
	logic [NCW-1:0] nc;
	logic           first, last_row_t, last_col_t, last_orow, last_ocol, emit;
	logic           in_acc, push, div_start, div_done;
	logic signed [ACC_W-1:0] acc_old, acc_new, div_quo;
	logic signed [XW-1:0]    acc_x;

	always_comb begin
		cf = (col_factor_q == '0) ? FCW'(1) :
			(32'(col_factor_q) > MAX_FACTOR) ? FCW'(MAX_FACTOR) : FCW'(col_factor_q);
		rf = (row_factor_q == '0) ? FCW'(1) :
			(32'(row_factor_q) > MAX_FACTOR) ? FCW'(MAX_FACTOR) : FCW'(row_factor_q);
		nr = (out_rows_q == '0) ? NRW'(1) :
			(32'(out_rows_q) > MAX_OUT_ROWS) ? NRW'(MAX_OUT_ROWS) : NRW'(out_rows_q);
		nc = (out_cols_q == '0) ? NCW'(1) :
			(32'(out_cols_q) > COL_LIMIT) ? NCW'(COL_LIMIT) : NCW'(out_cols_q);
		first      = (row_in_tile_q == '0) && (col_in_tile_q == '0);
		last_row_t = (32'(row_in_tile_q) + 1) >= 32'(rf);
		last_col_t = (32'(col_in_tile_q) + 1) >= 32'(cf);
		last_orow  = (32'(row_index_out_q) + 1) >= 32'(nr);
		last_ocol  = (32'(col_index_out_q) + 1) >= 32'(nc);
		emit       = last_row_t && last_col_t;
		acc_old    = first ? '0 : rd_data_s1;
		acc_x      = XW'(acc_old);
		if (mode_q == MODE_MAX) begin
			acc_new = (px_s1 > acc_x) ? ACC_W'(px_s1) : acc_old;
		end else begin
			acc_new = ACC_W'(acc_old + ACC_W'(px_s1));
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign push      = (state_q == ST_PUSH) && (!out_valid_q || out_ready);
	assign div_start = (state_q == ST_UPD) && emit && (mode_q == MODE_AVG);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_UPD;
			ST_UPD: begin
				if (!emit) state_d = ST_IDLE;
				else if (mode_q == MODE_AVG) state_d = ST_DIV;
				else state_d = ST_PUSH;
			end
			ST_DIV:  if (div_done) state_d = ST_PUSH;
			ST_PUSH: if (push) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SUM;
			col_factor_q <= 7'd1;
			row_factor_q <= 7'd1;
			out_rows_q   <= 11'd1;
			out_cols_q   <= 13'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:       mode_q       <= cfg_data[1:0];
				REG_COL_FACTOR: col_factor_q <= cfg_data[6:0];
				REG_ROW_FACTOR: row_factor_q <= cfg_data[6:0];
				REG_OUT_ROWS:   out_rows_q   <= cfg_data[10:0];
				REG_OUT_COLS:   out_cols_q   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_in_tile_q   <= '0;
			col_in_tile_q   <= '0;
			row_index_out_q <= '0;
			col_index_out_q <= '0;
		end else if (state_q == ST_UPD) begin
			if (!last_row_t) begin
				row_in_tile_q <= row_in_tile_q + 1'b1;
			end else begin
				row_in_tile_q <= '0;
				if (!last_orow) begin
					row_index_out_q <= row_index_out_q + 1'b1;
				end else begin
					row_index_out_q <= '0;
					if (!last_col_t) begin
						col_in_tile_q <= col_in_tile_q + 1'b1;
					end else begin
						col_in_tile_q   <= '0;
						col_index_out_q <= last_ocol ? '0 : col_index_out_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_data_s1 <= mem[row_index_out_q];
			px_s1      <= XW'(pixel);
		end
		if (state_q == ST_UPD) begin
			mem[row_index_out_q] <= acc_new;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			res_value_q <= acc_new;
			res_col_q   <= col_index_out_q;
			res_row_q   <= ROW_W'(row_index_out_q);
			res_last_q  <= last_orow && last_ocol;
		end else if (div_done) begin
			res_value_q <= div_quo;
		end
		if (push) begin
			value_q    <= res_value_q;
			out_col_q  <= res_col_q;
			out_row_q  <= res_row_q;
			out_last_q <= res_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	ibp_div #(
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (acc_new),
		.den   (DW'(cf * rf)),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign out_valid     = out_valid_q;
	assign value         = value_q;
	assign out_col       = out_col_q;
	assign out_row       = out_row_q;
	assign last_of_image = out_last_q;

	`IBP_ASSERT_NEXT(a_accept_updates, in_acc, state_q == ST_UPD)
	`IBP_ASSERT_IMPL(a_div_done_in_div, div_done, state_q == ST_DIV)
	`IBP_ASSERT_NEXT(a_push_fills_out, push, out_valid_q)
	`IBP_ASSERT_IMPL(a_div_only_avg, state_q == ST_DIV, mode_q == MODE_AVG)

endmodule
